// File: rtl/core/vpsf_pkg.sv
// Shared types and constants for the vertex projection snap filter.
// No dependencies; every other file of the block imports this package.
package vpsf_pkg;

	// Fixed point format and snap radius
	localparam int FRAC_BITS   = 12;
	localparam int SNAP_RADIUS = 10;
	localparam int ZOOM_FRAC   = 16;

	// Datapath widths
	localparam int COORD_W = 32;
	localparam int PIX_W   = 16;
	localparam int D_W     = COORD_W + 1;
	localparam int PROD_W  = 2 * D_W;
	localparam int S_W     = PROD_W - ZOOM_FRAC;
	localparam int SC_W    = PIX_W + FRAC_BITS;
	localparam int SUM_W   = ((S_W + 2 > SC_W) ? S_W + 2 : SC_W) + 1;
	localparam int DIFF_W  = ((COORD_W > SC_W) ? COORD_W : SC_W) + 1;
	localparam int DIST_W  = DIFF_W + 1;
	localparam logic [63:0] RADIUS_FX = 64'(SNAP_RADIUS) << FRAC_BITS;

	// Configuration register index
	localparam int CFG_IDX_W = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ZOOM          = 4'd0,
		REG_VIEW_CENTER_X = 4'd1,
		REG_VIEW_CENTER_Y = 4'd2,
		REG_VIEW_CENTER_Z = 4'd3,
		REG_SCREEN_CENTER = 4'd4,
		REG_PLANE         = 4'd5,
		REG_HEIGHT_FLOOR  = 4'd6,
		REG_POINTER_POS   = 4'd7
	} cfg_idx_t;

	// View plane codes
	typedef enum logic [2:0] {
		PLANE_PX  = 3'd0,
		PLANE_MX  = 3'd1,
		PLANE_PY  = 3'd2,
		PLANE_MY  = 3'd3,
		PLANE_PZ  = 3'd4,
		PLANE_MZ  = 3'd5,
		PLANE_ISO = 3'd6
	} plane_t;

	localparam logic [31:0] ZOOM_RESET = 32'h0001_0000;

	typedef struct packed {
		logic        [31:0] zoom;
		logic signed [31:0] view_center_x;
		logic signed [31:0] view_center_y;
		logic signed [31:0] view_center_z;
		logic        [31:0] screen_center;
		plane_t             plane;
		logic signed [31:0] height_floor;
		logic        [31:0] pointer_pos;
	} cfg_t;

	typedef struct packed {
		logic signed [31:0] vertex_x;
		logic signed [31:0] vertex_y;
		logic signed [31:0] vertex_z;
	} vertex_t;

	typedef struct packed {
		logic               hit;
		logic signed [31:0] screen_x;
		logic signed [31:0] screen_y;
	} result_t;

endpackage

// File: rtl/core/vertex_projection_snap_filter_core.sv
// Top level of the vertex projection snap filter: offset, zoom scaling,
// plane mapping, saturation and snap distance test. Uses vpsf_pkg, vpsf_cfg.
//
//  channel   handshake               payload
//  -------   ---------------------   --------------------------------------
//  request   start, busy             vertex (vertex_x, vertex_y, vertex_z)
//  result    done (one-cycle strobe) result (hit, screen_x, screen_y)
//  config    cfg_valid, cfg_ready    cfg_index, cfg_data
//
// One request per cycle; busy stays low, so start may be held high.
// From accept to done a request passes the offset, multiply, map and distance stages.
// The three zoom multipliers (33x33 signed) set the stage boundaries.
// Reset clears the pipeline valids and loads register reset values.
// The receiver cannot stall; each result shows for exactly one cycle.
module vertex_projection_snap_filter_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  vpsf_pkg::vertex_t             vertex,
	output logic                          done,
	output vpsf_pkg::result_t             result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [vpsf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data
);
	import vpsf_pkg::*;

	cfg_t cfg;

	vpsf_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	logic accept;
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// ---------------- stage 1: offset and height test ----------------
	logic signed [COORD_W-1:0] height;
	logic                      plane_ok;

	// Pick the raw height axis for the plane
	always_comb begin
		height   = vertex.vertex_x;
		plane_ok = 1'b1;
		case (cfg.plane)
			PLANE_PX, PLANE_MX:            height = vertex.vertex_x;
			PLANE_PY, PLANE_MY, PLANE_ISO: height = vertex.vertex_y;
			PLANE_PZ, PLANE_MZ:            height = vertex.vertex_z;
			default:                       plane_ok = 1'b0;
		endcase
	end

	logic                  valid_s1;
	logic                  pre_hit_s1;
	logic signed [D_W-1:0] d_x_s1, d_y_s1, d_z_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else         valid_s1 <= accept;
	end

	// Capture offsets from the view center
	always_ff @(posedge clk) begin
		if (accept) begin
			d_x_s1     <= D_W'(vertex.vertex_x) - D_W'(cfg.view_center_x);
			d_y_s1     <= D_W'(vertex.vertex_y) - D_W'(cfg.view_center_y);
			d_z_s1     <= D_W'(vertex.vertex_z) - D_W'(cfg.view_center_z);
			pre_hit_s1 <= plane_ok && (height >= cfg.height_floor);
		end
	end

	// ---------------- stage 2: zoom scaling ----------------
	logic signed [D_W-1:0]    zoom_s;
	logic signed [PROD_W-1:0] prod_x, prod_y, prod_z;

	assign zoom_s = $signed({1'b0, cfg.zoom});
	assign prod_x = d_x_s1 * zoom_s;
	assign prod_y = d_y_s1 * zoom_s;
	assign prod_z = d_z_s1 * zoom_s;

	logic                  valid_s2;
	logic                  pre_hit_s2;
	logic signed [S_W-1:0] s_x_s2, s_y_s2, s_z_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s2 <= 1'b0;
		else         valid_s2 <= valid_s1;
	end

	// Drop the zoom fraction; the arithmetic shift floors toward minus infinity
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			s_x_s2     <= prod_x[PROD_W-1:ZOOM_FRAC];
			s_y_s2     <= prod_y[PROD_W-1:ZOOM_FRAC];
			s_z_s2     <= prod_z[PROD_W-1:ZOOM_FRAC];
			pre_hit_s2 <= pre_hit_s1;
		end
	end

	// ---------------- stage 3: axis mapping and saturation ----------------
	logic signed [SUM_W-1:0] ex, ey, ez, half, map_a, map_b;
	logic signed [SUM_W-1:0] ctr_x, ctr_y, sum_x, sum_y;
	logic signed [PIX_W-1:0] sc_x, sc_y;

	assign ex   = SUM_W'(s_x_s2);
	assign ey   = SUM_W'(s_y_s2);
	assign ez   = SUM_W'(s_z_s2);
	assign half = ey >>> 1;

	// Map the scaled components onto the display axes
	always_comb begin
		map_a = '0;
		map_b = '0;
		case (cfg.plane)
			PLANE_PX:  begin map_a = ez;        map_b = -ey;        end
			PLANE_MX:  begin map_a = ey;        map_b = -ez;        end
			PLANE_PY:  begin map_a = ex;        map_b = -ez;        end
			PLANE_MY:  begin map_a = ez;        map_b = -ex;        end
			PLANE_PZ:  begin map_a = ey;        map_b = -ex;        end
			PLANE_MZ:  begin map_a = ex;        map_b = -ey;        end
			PLANE_ISO: begin map_a = ex - half; map_b = half - ez;  end
			default:   begin map_a = '0;        map_b = '0;         end
		endcase
	end

	assign sc_x  = $signed(cfg.screen_center[31:16]);
	assign sc_y  = $signed(cfg.screen_center[15:0]);
	assign ctr_x = SUM_W'(sc_x) <<< FRAC_BITS;
	assign ctr_y = SUM_W'(sc_y) <<< FRAC_BITS;
	assign sum_x = map_a + ctr_x;
	assign sum_y = map_b + ctr_y;

	function automatic logic signed [COORD_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
		logic [SUM_W-COORD_W:0] top;
		top = v[SUM_W-1:COORD_W-1];
		if (top == '0 || top == '1) sat32 = v[COORD_W-1:0];
		else if (v[SUM_W-1])        sat32 = {1'b1, {(COORD_W-1){1'b0}}};
		else                        sat32 = {1'b0, {(COORD_W-1){1'b1}}};
	endfunction

	logic                      valid_s3;
	logic                      pre_hit_s3;
	logic signed [COORD_W-1:0] scr_x_s3, scr_y_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s3 <= 1'b0;
		else         valid_s3 <= valid_s2;
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			scr_x_s3   <= sat32(sum_x);
			scr_y_s3   <= sat32(sum_y);
			pre_hit_s3 <= pre_hit_s2;
		end
	end

	// ---------------- stage 4: snap distance and result ----------------
	logic signed [PIX_W-1:0]  px, py;
	logic signed [DIFF_W-1:0] diff_x, diff_y;
	logic        [DIFF_W-1:0] abs_x, abs_y;
	logic        [DIST_W-1:0] snap_dist;
	logic                     near;

	assign px        = $signed(cfg.pointer_pos[31:16]);
	assign py        = $signed(cfg.pointer_pos[15:0]);
	assign diff_x    = DIFF_W'(scr_x_s3) - (DIFF_W'(px) <<< FRAC_BITS);
	assign diff_y    = DIFF_W'(scr_y_s3) - (DIFF_W'(py) <<< FRAC_BITS);
	assign abs_x     = diff_x[DIFF_W-1] ? DIFF_W'(-diff_x) : DIFF_W'(diff_x);
	assign abs_y     = diff_y[DIFF_W-1] ? DIFF_W'(-diff_y) : DIFF_W'(diff_y);
	assign snap_dist = {1'b0, abs_x} + {1'b0, abs_y};
	assign near      = (64'(snap_dist) < RADIUS_FX);

	logic    done_q;
	result_t result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else         done_q <= valid_s3;
	end

	// Hold the result for its single strobe cycle
	always_ff @(posedge clk) begin
		if (valid_s3) begin
			result_q.hit      <= pre_hit_s3 && near;
			result_q.screen_x <= scr_x_s3;
			result_q.screen_y <= scr_y_s3;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// ---------------- checks ----------------
	a_accept_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##4 done)
		else $error("accepted request did not produce a result after four cycles");

	a_no_spurious_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(valid_s3))
		else $error("result strobe without a request in the last stage");

	a_hit_valid_plane: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.hit) |-> (cfg.plane != plane_t'(3'd7)))
		else $error("hit reported for an undefined plane code");

	a_hit_near: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && !near) |=> !result.hit)
		else $error("hit reported outside the snap radius");

endmodule

// File: rtl/core/vpsf_cfg.sv
// Configuration register file of the vertex projection snap filter.
// Depends on vpsf_pkg for the register index codes and the cfg_t bundle.
module vpsf_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [vpsf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data,
	output vpsf_pkg::cfg_t                cfg
);
	import vpsf_pkg::*;

	cfg_t cfg_q;

	// Always take writes; the register file never stalls
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// Update the addressed register, drop writes beyond the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.zoom          <= ZOOM_RESET;
			cfg_q.view_center_x <= '0;
			cfg_q.view_center_y <= '0;
			cfg_q.view_center_z <= '0;
			cfg_q.screen_center <= '0;
			cfg_q.plane         <= PLANE_PX;
			cfg_q.height_floor  <= '0;
			cfg_q.pointer_pos   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				REG_ZOOM:          cfg_q.zoom          <= cfg_data;
				REG_VIEW_CENTER_X: cfg_q.view_center_x <= $signed(cfg_data);
				REG_VIEW_CENTER_Y: cfg_q.view_center_y <= $signed(cfg_data);
				REG_VIEW_CENTER_Z: cfg_q.view_center_z <= $signed(cfg_data);
				REG_SCREEN_CENTER: cfg_q.screen_center <= cfg_data;
				REG_PLANE:         cfg_q.plane         <= plane_t'(cfg_data[2:0]);
				REG_HEIGHT_FLOOR:  cfg_q.height_floor  <= $signed(cfg_data);
				REG_POINTER_POS:   cfg_q.pointer_pos   <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule
